@@ design/fixed_block_pool_allocator_assert.svh @@
// ============================================================================
// Fixed block pool allocator assertion macros
// Concurrent assertion wrappers that compile away when SYNTHESIS is defined.
// ============================================================================
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_ASSERT_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define FBPA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define FBPA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FBPA_ASSERT_SAME(label, ante, cons, msg)
`define FBPA_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

@@ design/fbpa_pkg.sv @@
// ============================================================================
// Fixed block pool allocator package
// Shared constants, codes and transaction types of the allocator.
// ============================================================================
`default_nettype none

package fbpa_pkg;

    localparam int NUM_BLOCKS      = 1024;
    localparam int ADDR_W          = 32;
    localparam int STRIDE_W        = 17;
    localparam int CNT_W           = 11;
    localparam int CFG_IDX_W       = 2;
    localparam int IDX_W           = $clog2(NUM_BLOCKS);
    localparam int PROD_W          = STRIDE_W + CNT_W;
    localparam int END_W           = ADDR_W + 1;
    localparam int ALIGN_BITS      = 3;
    localparam int MIN_BLOCK_BYTES = 1 << ALIGN_BITS;
    localparam int DVS_W           = STRIDE_W + IDX_W - 1;
    localparam int DIV_STEP_W      = $clog2(IDX_W + 1);

    localparam logic [CNT_W-1:0] LINK_NULL = CNT_W'(NUM_BLOCKS);
    localparam logic [END_W-1:0] END_LIMIT = END_W'(1) << ADDR_W;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_INIT  = 2'd2,
        OP_NOP   = 2'd3
    } fbpa_op_e;

    typedef enum logic [2:0] {
        STATUS_OK     = 3'd0,
        STATUS_EMPTY  = 3'd1,
        STATUS_RANGE  = 3'd2,
        STATUS_ALIGN  = 3'd3,
        STATUS_FULL   = 3'd4,
        STATUS_CONFIG = 3'd5
    } fbpa_status_e;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE_ADDRESS = 2'd0,
        REG_BLOCK_BYTES  = 2'd1,
        REG_BLOCK_COUNT  = 2'd2
    } fbpa_reg_e;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_INIT_CHK,
        S_INIT_WALK,
        S_FREE_DIV,
        S_FINISH
    } fbpa_state_e;

    typedef struct packed {
        fbpa_op_e           command;
        logic [ADDR_W-1:0]  free_address;
    } fbpa_req_t;

    typedef struct packed {
        fbpa_status_e       status;
        logic [ADDR_W-1:0]  block_address;
        logic [CNT_W-1:0]   available_count;
    } fbpa_rsp_t;

    typedef struct packed {
        logic         capture;
        logic         mem_rd;
        logic         mul_en;
        logic         mul_cfg;
        logic         div_start;
        logic         walk_clr;
        logic         walk_step;
        logic         set_status;
        fbpa_status_e status_code;
        logic         commit;
    } fbpa_cmd_t;

    typedef struct packed {
        fbpa_op_e op;
        logic     pool_ready;
        logic     head_null;
        logic     out_of_range;
        logic     cfg_bad;
        logic     walk_last;
        logic     div_done;
        logic     misaligned;
        logic     pool_full;
        logic     out_free;
    } fbpa_stat_t;

endpackage

`default_nettype wire

@@ design/fbpa_div.sv @@
// ============================================================================
// Fixed block pool allocator divider
// Restoring divider that yields the block index of a pool offset, one
// quotient bit per cycle, and flags a nonzero remainder.
// ============================================================================
`default_nettype none

module fbpa_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [fbpa_pkg::ADDR_W-1:0]   dividend,
    input  logic [fbpa_pkg::STRIDE_W-1:0] divisor,
    output logic                          done,
    output logic [fbpa_pkg::IDX_W-1:0]    quotient,
    output logic                          rem_nonzero
);
    import fbpa_pkg::*;

    logic [ADDR_W-1:0]     rem_reg;
    logic [DVS_W-1:0]      dvs_reg;
    logic [IDX_W-1:0]      quot_reg;
    logic [DIV_STEP_W-1:0] step_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [ADDR_W-1:0]     dvs_ext;
    logic                  fits;

    assign dvs_ext = ADDR_W'(dvs_reg);
    assign fits    = rem_reg >= dvs_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + DIV_STEP_W'(1);
            if (step_reg == DIV_STEP_W'(IDX_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= dividend;
            dvs_reg  <= DVS_W'(divisor) << (IDX_W - 1);
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - dvs_ext;
            end
            quot_reg <= {quot_reg[IDX_W-2:0], fits};
            dvs_reg  <= dvs_reg >> 1;
        end
    end

    assign done        = done_reg;
    assign quotient    = quot_reg;
    assign rem_nonzero = rem_reg != '0;

endmodule

`default_nettype wire

@@ design/fbpa_dpath.sv @@
// ============================================================================
// Fixed block pool allocator datapath
// Configuration registers, pool state, link memory, shared multiplier,
// divider and the registered response.
// ============================================================================
`default_nettype none

module fbpa_dpath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fbpa_pkg::ADDR_W-1:0]    cfg_data,
    input  fbpa_pkg::fbpa_req_t            req,
    input  fbpa_pkg::fbpa_cmd_t            cmd,
    output fbpa_pkg::fbpa_stat_t           stat,
    input  logic                           rsp_ready,
    output logic                           rsp_valid,
    output fbpa_pkg::fbpa_rsp_t            rsp
);
    import fbpa_pkg::*;

    logic [ADDR_W-1:0]   cfg_base_reg;
    logic [STRIDE_W-1:0] cfg_bytes_reg;
    logic [CNT_W-1:0]    cfg_count_reg;

    logic [ADDR_W-1:0]   pool_base_reg,   pool_base_next;
    logic [STRIDE_W-1:0] pool_stride_reg, pool_stride_next;
    logic [CNT_W-1:0]    pool_blocks_reg, pool_blocks_next;
    logic [END_W-1:0]    pool_end_reg,    pool_end_next;
    logic [CNT_W-1:0]    head_reg,        head_next;
    logic [CNT_W-1:0]    free_count_reg,  free_count_next;
    logic                pool_ready_reg,  pool_ready_next;
    logic                rsp_valid_reg,   rsp_valid_next;
    fbpa_rsp_t           rsp_reg,         rsp_next;

    fbpa_op_e            op_reg;
    logic [ADDR_W-1:0]   req_addr_reg;
    fbpa_status_e        status_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [IDX_W-1:0]    walk_idx_reg;
    logic [CNT_W-1:0]    rd_link_reg;
    logic [CNT_W-1:0]    link_mem [NUM_BLOCKS];

    logic [CNT_W-1:0]    mul_a;
    logic [STRIDE_W-1:0] mul_b;
    logic [PROD_W-1:0]   mul_p;
    logic [END_W-1:0]    cfg_end;
    logic [ADDR_W-1:0]   alloc_addr;
    logic                walk_last;
    logic [CNT_W-1:0]    walk_link;
    logic                mem_we;
    logic [IDX_W-1:0]    wr_idx;
    logic [CNT_W-1:0]    wr_link;
    logic                div_done;
    logic [IDX_W-1:0]    div_quot;
    logic                div_rem_nz;

    fbpa_div u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (cmd.div_start),
        .dividend    (req_addr_reg - pool_base_reg),
        .divisor     (pool_stride_reg),
        .done        (div_done),
        .quotient    (div_quot),
        .rem_nonzero (div_rem_nz)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_base_reg  <= '0;
            cfg_bytes_reg <= STRIDE_W'(MIN_BLOCK_BYTES);
            cfg_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BASE_ADDRESS: cfg_base_reg  <= cfg_data;
                REG_BLOCK_BYTES:  cfg_bytes_reg <= cfg_data[STRIDE_W-1:0];
                REG_BLOCK_COUNT:  cfg_count_reg <= cfg_data[CNT_W-1:0];
                default:          ;
            endcase
        end
    end

    assign mul_a = cmd.mul_cfg ? cfg_count_reg : head_reg;
    assign mul_b = cmd.mul_cfg ? cfg_bytes_reg : pool_stride_reg;
    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    assign cfg_end    = {1'b0, cfg_base_reg} + END_W'(prod_reg);
    assign alloc_addr = pool_base_reg + ADDR_W'(prod_reg);
    assign walk_last  = (CNT_W'(walk_idx_reg) + CNT_W'(1)) == cfg_count_reg;
    assign walk_link  = walk_last ? LINK_NULL : CNT_W'(walk_idx_reg) + CNT_W'(1);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg       <= req.command;
            req_addr_reg <= req.free_address;
        end
        if (cmd.set_status)
        begin
            status_reg <= cmd.status_code;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= mul_p;
        end
        if (cmd.walk_clr)
        begin
            walk_idx_reg <= '0;
        end
        else if (cmd.walk_step)
        begin
            walk_idx_reg <= walk_idx_reg + IDX_W'(1);
        end
        rsp_reg <= rsp_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            link_mem[wr_idx] <= wr_link;
        end
        if (cmd.mem_rd)
        begin
            rd_link_reg <= link_mem[head_reg[IDX_W-1:0]];
        end
    end

    always_comb
    begin
        head_next        = head_reg;
        free_count_next  = free_count_reg;
        pool_ready_next  = pool_ready_reg;
        pool_base_next   = pool_base_reg;
        pool_stride_next = pool_stride_reg;
        pool_blocks_next = pool_blocks_reg;
        pool_end_next    = pool_end_reg;
        rsp_next         = rsp_reg;
        rsp_valid_next   = rsp_valid_reg & ~rsp_ready;
        mem_we           = cmd.walk_step;
        wr_idx           = walk_idx_reg;
        wr_link          = walk_link;
        if (cmd.commit)
        begin
            rsp_valid_next         = 1'b1;
            rsp_next.status        = status_reg;
            rsp_next.block_address = '0;
            if (status_reg == STATUS_OK)
            begin
                case (op_reg)
                    OP_ALLOC:
                    begin
                        head_next = rd_link_reg;
                        if (free_count_reg != '0)
                        begin
                            free_count_next = free_count_reg - CNT_W'(1);
                        end
                        rsp_next.block_address = alloc_addr;
                    end
                    OP_FREE:
                    begin
                        mem_we          = 1'b1;
                        wr_idx          = div_quot;
                        wr_link         = head_reg;
                        head_next       = CNT_W'(div_quot);
                        free_count_next = free_count_reg + CNT_W'(1);
                    end
                    OP_INIT:
                    begin
                        head_next        = '0;
                        free_count_next  = cfg_count_reg;
                        pool_ready_next  = 1'b1;
                        pool_base_next   = cfg_base_reg;
                        pool_stride_next = cfg_bytes_reg;
                        pool_blocks_next = cfg_count_reg;
                        pool_end_next    = cfg_end;
                    end
                    default: ;
                endcase
            end
            rsp_next.available_count = free_count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg        <= LINK_NULL;
            free_count_reg  <= '0;
            pool_ready_reg  <= 1'b0;
            pool_base_reg   <= '0;
            pool_stride_reg <= '0;
            pool_blocks_reg <= '0;
            pool_end_reg    <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            head_reg        <= head_next;
            free_count_reg  <= free_count_next;
            pool_ready_reg  <= pool_ready_next;
            pool_base_reg   <= pool_base_next;
            pool_stride_reg <= pool_stride_next;
            pool_blocks_reg <= pool_blocks_next;
            pool_end_reg    <= pool_end_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    always_comb
    begin
        stat.op           = op_reg;
        stat.pool_ready   = pool_ready_reg;
        stat.head_null    = head_reg == LINK_NULL;
        stat.out_of_range = (req_addr_reg < pool_base_reg)
                            || (END_W'(req_addr_reg) >= pool_end_reg);
        stat.cfg_bad      = (cfg_count_reg == '0)
                            || (cfg_count_reg > CNT_W'(NUM_BLOCKS))
                            || (cfg_bytes_reg < STRIDE_W'(MIN_BLOCK_BYTES))
                            || (cfg_bytes_reg[ALIGN_BITS-1:0] != '0)
                            || (cfg_end > END_LIMIT);
        stat.walk_last    = walk_last;
        stat.div_done     = div_done;
        stat.misaligned   = div_rem_nz;
        stat.pool_full    = free_count_reg >= pool_blocks_reg;
        stat.out_free     = ~rsp_valid_reg | rsp_ready;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

@@ design/fbpa_ctrl.sv @@
// ============================================================================
// Fixed block pool allocator controller
// State machine that sequences each command through the datapath.
// ============================================================================
`default_nettype none

module fbpa_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  fbpa_pkg::fbpa_stat_t stat,
    output fbpa_pkg::fbpa_cmd_t  cmd
);
    import fbpa_pkg::*;

    fbpa_state_e state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (stat.op)
                    OP_FREE:
                    begin
                        if (stat.pool_ready && !stat.out_of_range)
                        begin
                            state_next = S_FREE_DIV;
                        end
                        else
                        begin
                            state_next = S_FINISH;
                        end
                    end
                    OP_INIT: state_next = S_INIT_CHK;
                    default: state_next = S_FINISH;
                endcase
            end
            S_INIT_CHK:
            begin
                state_next = stat.cfg_bad ? S_FINISH : S_INIT_WALK;
            end
            S_INIT_WALK:
            begin
                if (stat.walk_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FREE_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd             = '0;
        cmd.status_code = STATUS_OK;
        req_ready       = state_reg == S_IDLE;
        cmd.capture     = req_valid && (state_reg == S_IDLE);
        case (state_reg)
            S_DECODE:
            begin
                cmd.set_status = 1'b1;
                case (stat.op)
                    OP_ALLOC:
                    begin
                        cmd.mem_rd = 1'b1;
                        cmd.mul_en = 1'b1;
                        if (!stat.pool_ready || stat.head_null)
                        begin
                            cmd.status_code = STATUS_EMPTY;
                        end
                    end
                    OP_FREE:
                    begin
                        if (!stat.pool_ready)
                        begin
                            cmd.status_code = STATUS_EMPTY;
                        end
                        else if (stat.out_of_range)
                        begin
                            cmd.status_code = STATUS_RANGE;
                        end
                        else
                        begin
                            cmd.div_start = 1'b1;
                        end
                    end
                    OP_INIT:
                    begin
                        cmd.mul_en  = 1'b1;
                        cmd.mul_cfg = 1'b1;
                    end
                    default: ;
                endcase
            end
            S_INIT_CHK:
            begin
                if (stat.cfg_bad)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = STATUS_CONFIG;
                end
                else
                begin
                    cmd.walk_clr = 1'b1;
                end
            end
            S_INIT_WALK:
            begin
                cmd.walk_step = 1'b1;
            end
            S_FREE_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.set_status = 1'b1;
                    if (stat.misaligned)
                    begin
                        cmd.status_code = STATUS_ALIGN;
                    end
                    else if (stat.pool_full)
                    begin
                        cmd.status_code = STATUS_FULL;
                    end
                end
            end
            S_FINISH:
            begin
                cmd.commit = stat.out_free;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

@@ design/fixed_block_pool_allocator.sv @@
// ============================================================================
// Fixed block pool allocator
// Hands out and takes back equal-sized blocks of a pool region through a
// linked free list kept in a 1024 x 11 link memory, one result per command.
// Each command runs through the controller from its acceptance back to idle,
// where the next command can first be taken; its result becomes valid on
// that return. An allocate, a no-op and a free that fails the readiness or
// range check pass through decode and finish only; for an allocate, the
// registered link-memory read and the address multiply are done in decode.
// A free that passes the range check waits in the divide state while the
// divider finds the block index one bit per cycle. An init links one block
// per cycle through the single memory write port, or goes from its
// configuration check to finish on a rejected configuration. A result waits
// in an output register, so the next command is taken while it is still
// unread; a command that finishes before that result is taken waits for it.
// Configuration writes are always ready and must be issued only while no
// command is in flight. The link memory needs no clearing after reset.
// ============================================================================
`default_nettype none
`include "fixed_block_pool_allocator_assert.svh"

module fixed_block_pool_allocator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fbpa_pkg::ADDR_W-1:0]    cfg_data,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  fbpa_pkg::fbpa_req_t            req,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output fbpa_pkg::fbpa_rsp_t            rsp
);
    import fbpa_pkg::*;

    fbpa_cmd_t  cmd;
    fbpa_stat_t stat;
    logic       cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid & cfg_ready;

    fbpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    fbpa_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_ready (rsp_ready),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

    `FBPA_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "Transaction accepted while busy")
    `FBPA_ASSERT_SAME(a_commit_slot_free, cmd.commit, stat.out_free, "Result overwrote an unread response")
    `FBPA_ASSERT_SAME(a_addr_zero_on_error, rsp_valid && (rsp.status != STATUS_OK), rsp.block_address == '0, "Failed command returned an address")
    `FBPA_ASSERT_SAME(a_count_bound, rsp_valid, rsp.available_count <= CNT_W'(NUM_BLOCKS), "Available count exceeds pool size")

endmodule

`default_nettype wire
